// ----- rtl/core/pim_pkg.sv -----
`default_nettype none

package pim_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int DATA_W         = 32;
    localparam int DT_W           = 20;
    localparam int FRAC_W         = 16;
    localparam int GP_W           = DATA_W + DT_W + 1;
    localparam int GD_W           = GP_W - FRAC_W;
    localparam int LIFE_W         = 31;
    localparam int CFG_IDX_W      = 2;
    localparam int SLOT_W         = 6;
    localparam int LIVE_W         = 7;

    localparam logic [LIFE_W-1:0] LIFE_RST = 31'd65536;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_REC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] life;
    } t_slot;

    typedef struct packed {
        logic [1:0]               kind;
        logic [LIVE_W-1:0]        live_total;
        logic [SLOT_W-1:0]        slot;
        logic                     valid_res;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] life;
        logic                     last;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/core/particle_pool_integrator.sv -----
// tick: one slot read per cycle through the update pipeline
// add: next-fit scan of the live flags, one slot per cycle
// dump: dead slots are skipped, each live slot is read to emit a record
// the next request can be taken in the cycle after the last result is registered
// reset (synchronous, active low) clears the live flags, counters, state and valid flags;
// slot data memory is not cleared and needs no clearing pass
`default_nettype none

module particle_pool_integrator #(
    parameter int POOL_DEPTH = pim_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [pim_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [pim_pkg::DATA_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic [pim_pkg::DT_W-1:0]             i_delta_time,
    input  wire logic signed [pim_pkg::DATA_W-1:0]    i_vel_x,
    input  wire logic signed [pim_pkg::DATA_W-1:0]    i_vel_y,
    input  wire logic signed [pim_pkg::DATA_W-1:0]    i_pos_x,
    input  wire logic signed [pim_pkg::DATA_W-1:0]    i_pos_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [1:0]                                o_kind,
    output logic [pim_pkg::LIVE_W-1:0]                o_live_total,
    output logic [pim_pkg::SLOT_W-1:0]                o_slot,
    output logic                                      o_valid_res,
    output logic signed [pim_pkg::DATA_W-1:0]         o_out_pos_x,
    output logic signed [pim_pkg::DATA_W-1:0]         o_out_pos_y,
    output logic signed [pim_pkg::DATA_W-1:0]         o_out_life,
    output logic                                      o_last
);
    import pim_pkg::*;

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TPRE  = 8'b0000_0010,
        S_TRUN  = 8'b0000_0100,
        S_TDONE = 8'b0000_1000,
        S_ASCAN = 8'b0001_0000,
        S_AACK  = 8'b0010_0000,
        S_DSCAN = 8'b0100_0000,
        S_DREAD = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic signed [DATA_W-1:0] r_grav_x, r_grav_y;
    logic [LIFE_W-1:0]       r_lifetime;
    logic [POOL_DEPTH-1:0]   r_alive, n_alive;
    logic [AW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_n, n_n;
    logic [CW-1:0]           r_live, n_live;
    logic [CW-1:0]           r_tick_cnt, n_tick_cnt;
    logic [AW-1:0]           r_last_filled, n_last_filled;
    logic                    r_hit, n_hit;
    logic                    r_pend_v, n_pend_v;
    t_res                    r_pend, n_pend;
    logic                    r_out_v;
    t_res                    r_out;
    logic [DT_W-1:0]         r_dt;
    t_slot                   r_new;

    logic                    accept, out_free, push;
    t_res                    res, rec;
    logic [AW-1:0]           ptr_next;
    logic                    cnt_last, cnt_done;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr;
    t_slot                   mem_wdata, mem_rdata;
    logic                    eu_load, eu_issue;
    logic                    pipe_busy, wb_en, wb_live;
    logic [AW-1:0]           wb_addr;
    t_slot                   wb_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_v || i_out_ready;
    assign ptr_next   = (r_ptr == AW'(POOL_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    assign cnt_last   = (r_cnt == CW'(POOL_DEPTH - 1));
    assign cnt_done   = (r_cnt == CW'(POOL_DEPTH));

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_x   <= '0;
            r_grav_y   <= '0;
            r_lifetime <= LIFE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAV_X:   r_grav_x   <= i_cfg_data;
                CFG_GRAV_Y:   r_grav_y   <= i_cfg_data;
                CFG_LIFETIME: r_lifetime <= i_cfg_data[LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    pim_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    pim_euler #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_euler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (eu_load),
        .i_grav_x     (r_grav_x),
        .i_grav_y     (r_grav_y),
        .i_dt         (r_dt),
        .i_issue      (eu_issue),
        .i_issue_live (r_alive[r_ptr]),
        .i_issue_addr (r_ptr),
        .i_rd         (mem_rdata),
        .o_busy       (pipe_busy),
        .o_wb_en      (wb_en),
        .o_wb_live    (wb_live),
        .o_wb_addr    (wb_addr),
        .o_wb_data    (wb_data)
    );

    always_comb begin
        rec.kind       = KIND_REC;
        rec.live_total = '0;
        rec.slot       = SLOT_W'(r_ptr);
        rec.valid_res  = 1'b1;
        rec.pos_x      = mem_rdata.pos_x;
        rec.pos_y      = mem_rdata.pos_y;
        rec.life       = mem_rdata.life;
        rec.last       = 1'b0;
    end

    always_comb begin
        n_state       = r_state;
        n_alive       = r_alive;
        n_ptr         = r_ptr;
        n_cnt         = r_cnt;
        n_n           = r_n;
        n_live        = r_live;
        n_tick_cnt    = r_tick_cnt;
        n_last_filled = r_last_filled;
        n_hit         = r_hit;
        n_pend_v      = r_pend_v;
        n_pend        = r_pend;
        push          = 1'b0;
        res           = '0;
        mem_we        = 1'b0;
        mem_waddr     = r_ptr;
        mem_wdata     = wb_data;
        mem_re        = 1'b0;
        eu_load       = 1'b0;
        eu_issue      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_TICK: begin
                            n_state = S_TPRE;
                        end
                        OP_ADD: begin
                            n_state = S_ASCAN;
                            n_ptr   = r_last_filled;
                            n_cnt   = '0;
                        end
                        OP_DUMP: begin
                            n_state  = S_DSCAN;
                            n_ptr    = '0;
                            n_cnt    = '0;
                            n_n      = '0;
                            n_pend_v = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_TPRE: begin
                eu_load = 1'b1;
                n_ptr   = '0;
                n_cnt   = '0;
                n_live  = '0;
                n_state = S_TRUN;
            end
            S_TRUN: begin
                if (!cnt_done) begin
                    mem_re   = 1'b1;
                    eu_issue = 1'b1;
                    n_ptr    = ptr_next;
                    n_cnt    = r_cnt + 1'b1;
                end
                if (wb_en) begin
                    mem_we           = 1'b1;
                    mem_waddr        = wb_addr;
                    n_alive[wb_addr] = wb_live;
                    if (wb_live) begin
                        n_live = r_live + 1'b1;
                    end
                end
                if (cnt_done && !pipe_busy) begin
                    n_state = S_TDONE;
                end
            end
            S_TDONE: begin
                res.kind       = KIND_TICK;
                res.live_total = LIVE_W'(r_live);
                res.last       = 1'b1;
                if (out_free) begin
                    push       = 1'b1;
                    n_tick_cnt = r_live;
                    n_state    = S_IDLE;
                end
            end
            S_ASCAN: begin
                if (!r_alive[r_ptr]) begin
                    n_hit   = 1'b1;
                    n_state = S_AACK;
                end else if (cnt_last) begin
                    n_hit   = 1'b0;
                    n_state = S_AACK;
                end else begin
                    n_ptr = ptr_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_AACK: begin
                res.kind      = KIND_ADD;
                res.slot      = r_hit ? SLOT_W'(r_ptr) : '0;
                res.valid_res = r_hit;
                res.last      = 1'b1;
                mem_wdata      = r_new;
                mem_wdata.life = {1'b0, r_lifetime};
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                    if (r_hit) begin
                        mem_we         = 1'b1;
                        n_alive[r_ptr] = |r_lifetime;
                        n_last_filled  = r_ptr;
                    end
                end
            end
            S_DSCAN: begin
                if (cnt_done || r_n == r_tick_cnt) begin
                    if (r_pend_v) begin
                        res      = r_pend;
                        res.last = 1'b1;
                    end else begin
                        res.kind = KIND_REC;
                        res.last = 1'b1;
                    end
                    if (out_free) begin
                        push    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_alive[r_ptr]) begin
                    mem_re  = 1'b1;
                    n_state = S_DREAD;
                end else begin
                    n_ptr = ptr_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DREAD: begin
                // hold the newest record back until the next one is known
                res = r_pend;
                if (!r_pend_v || out_free) begin
                    push     = r_pend_v;
                    n_pend   = rec;
                    n_pend_v = 1'b1;
                    n_n      = r_n + 1'b1;
                    n_ptr    = ptr_next;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_DSCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_alive       <= '0;
            r_ptr         <= '0;
            r_cnt         <= '0;
            r_n           <= '0;
            r_live        <= '0;
            r_tick_cnt    <= '0;
            r_last_filled <= '0;
            r_hit         <= 1'b0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_alive       <= n_alive;
            r_ptr         <= n_ptr;
            r_cnt         <= n_cnt;
            r_n           <= n_n;
            r_live        <= n_live;
            r_tick_cnt    <= n_tick_cnt;
            r_last_filled <= n_last_filled;
            r_hit         <= n_hit;
            r_pend_v      <= n_pend_v;
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (push) begin
            r_out <= res;
        end
        if (accept) begin
            r_dt        <= i_delta_time;
            r_new.vel_x <= i_vel_x;
            r_new.vel_y <= i_vel_y;
            r_new.pos_x <= i_pos_x;
            r_new.pos_y <= i_pos_y;
            r_new.life  <= '0;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_kind       = r_out.kind;
    assign o_live_total = r_out.live_total;
    assign o_slot       = r_out.slot;
    assign o_valid_res  = r_out.valid_res;
    assign o_out_pos_x  = r_out.pos_x;
    assign o_out_pos_y  = r_out.pos_y;
    assign o_out_life   = r_out.life;
    assign o_last       = r_out.last;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("slot memory written while idle");

    a_pipe_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_TRUN) |-> !pipe_busy)
        else $error("update pipeline active outside a tick");

    a_dump_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN || r_state == S_DREAD) |-> (r_n <= r_tick_cnt))
        else $error("dump emitted more records than the tick count");

endmodule

`default_nettype wire

// ----- rtl/core/pim_store.sv -----
`default_nettype none

module pim_store #(
    parameter int POOL_DEPTH = pim_pkg::POOL_DEPTH_DEF,
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire pim_pkg::t_slot i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output pim_pkg::t_slot      o_rdata
);
    import pim_pkg::*;

    t_slot r_mem [POOL_DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/pim_euler.sv -----
`default_nettype none

module pim_euler #(
    parameter int POOL_DEPTH = pim_pkg::POOL_DEPTH_DEF,
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire logic signed [pim_pkg::DATA_W-1:0] i_grav_x,
    input  wire logic signed [pim_pkg::DATA_W-1:0] i_grav_y,
    input  wire logic [pim_pkg::DT_W-1:0]          i_dt,
    input  wire logic                              i_issue,
    input  wire logic                              i_issue_live,
    input  wire logic [AW-1:0]                     i_issue_addr,
    input  wire pim_pkg::t_slot                    i_rd,
    output logic                                   o_busy,
    output logic                                   o_wb_en,
    output logic                                   o_wb_live,
    output logic [AW-1:0]                          o_wb_addr,
    output pim_pkg::t_slot                         o_wb_data
);
    import pim_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [GD_W-1:0]   b
    );
        logic signed [GD_W:0] s;
        s = {{(GD_W+1-DATA_W){a[DATA_W-1]}}, a} + {b[GD_W-1], b};
        if (s[GD_W:DATA_W-1] == '0 || s[GD_W:DATA_W-1] == '1) begin
            sat_add = s[DATA_W-1:0];
        end else if (s[GD_W]) begin
            sat_add = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_add = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic signed [GP_W-1:0] r_gp_x, r_gp_y;
    logic                   r_s1_v, r_s1_live;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_s2_v, r_s2_live;
    logic [AW-1:0]          r_s2_addr;
    t_slot                  r_s2;
    logic                   r_s3_v, r_s3_live;
    logic [AW-1:0]          r_s3_addr;
    t_slot                  r_s3;
    logic signed [GP_W-1:0] r_s3_px, r_s3_py;
    logic signed [DATA_W-1:0] life_new;

    // gravity step is the same for every slot of a tick
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gp_x <= i_grav_x * $signed({1'b0, i_dt});
            r_gp_y <= i_grav_y * $signed({1'b0, i_dt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // stage 1: memory data arrives, velocity update
    // stage 2: velocity times dt
    always_ff @(posedge i_clk) begin
        r_s1_live  <= i_issue_live;
        r_s1_addr  <= i_issue_addr;
        r_s2_live  <= r_s1_live;
        r_s2_addr  <= r_s1_addr;
        r_s2.vel_x <= sat_add(i_rd.vel_x, r_gp_x[GP_W-1:FRAC_W]);
        r_s2.vel_y <= sat_add(i_rd.vel_y, r_gp_y[GP_W-1:FRAC_W]);
        r_s2.pos_x <= i_rd.pos_x;
        r_s2.pos_y <= i_rd.pos_y;
        r_s2.life  <= i_rd.life;
        r_s3_live  <= r_s2_live;
        r_s3_addr  <= r_s2_addr;
        r_s3       <= r_s2;
        r_s3_px    <= r_s2.vel_x * $signed({1'b0, i_dt});
        r_s3_py    <= r_s2.vel_y * $signed({1'b0, i_dt});
    end

    // stage 3: position and life, write back
    always_comb begin
        life_new        = r_s3.life - {{(DATA_W-DT_W){1'b0}}, i_dt};
        o_wb_data.vel_x = r_s3.vel_x;
        o_wb_data.vel_y = r_s3.vel_y;
        o_wb_data.pos_x = sat_add(r_s3.pos_x, r_s3_px[GP_W-1:FRAC_W]);
        o_wb_data.pos_y = sat_add(r_s3.pos_y, r_s3_py[GP_W-1:FRAC_W]);
        o_wb_data.life  = life_new;
    end

    assign o_wb_en   = r_s3_v && r_s3_live;
    assign o_wb_live = !life_new[DATA_W-1] && (life_new != '0);
    assign o_wb_addr = r_s3_addr;
    assign o_busy    = r_s1_v || r_s2_v || r_s3_v;

endmodule

`default_nettype wire

// ----- dv/particle_pool_integrator_tb.sv -----
`timescale 1ns / 1ps

module particle_pool_integrator_tb;
    import pim_pkg::*;

    localparam int POOL_DEPTH = POOL_DEPTH_DEF;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int DRAIN_PAUSE = 2 * POOL_DEPTH + 8;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [DATA_W-1:0]           i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [1:0]                  i_opcode = '0;
    logic [DT_W-1:0]             i_delta_time = '0;
    logic signed [DATA_W-1:0]    i_vel_x = '0;
    logic signed [DATA_W-1:0]    i_vel_y = '0;
    logic signed [DATA_W-1:0]    i_pos_x = '0;
    logic signed [DATA_W-1:0]    i_pos_y = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  o_kind;
    logic [LIVE_W-1:0]           o_live_total;
    logic [SLOT_W-1:0]           o_slot;
    logic                        o_valid_res;
    logic signed [DATA_W-1:0]    o_out_pos_x;
    logic signed [DATA_W-1:0]    o_out_pos_y;
    logic signed [DATA_W-1:0]    o_out_life;
    logic                        o_last;

    particle_pool_integrator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_delta_time (i_delta_time),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_live_total (o_live_total),
        .o_slot       (o_slot),
        .o_valid_res  (o_valid_res),
        .o_out_pos_x  (o_out_pos_x),
        .o_out_pos_y  (o_out_pos_y),
        .o_out_life   (o_out_life),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // predicted pool state and register copies
    logic signed [DATA_W-1:0] cfg_gx = '0;
    logic signed [DATA_W-1:0] cfg_gy = '0;
    logic [LIFE_W-1:0]        cfg_life = LIFE_RST;
    logic signed [DATA_W-1:0] pool_vx [POOL_DEPTH];
    logic signed [DATA_W-1:0] pool_vy [POOL_DEPTH];
    logic signed [DATA_W-1:0] pool_px [POOL_DEPTH];
    logic signed [DATA_W-1:0] pool_py [POOL_DEPTH];
    logic signed [DATA_W-1:0] pool_life [POOL_DEPTH];
    int                       fill_ptr = 0;
    bit                       fill_ptr_ok = 1'b0;
    int                       tick_live = 0;

    t_res due_results[$];
    t_res seen_want;
    int   err_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   stall_req = 0;
    int   stall_left = 0;

    function automatic logic signed [DATA_W-1:0] sat32(input longint v);
        if (v > S32_MAX) return S32_MAX[DATA_W-1:0];
        if (v < S32_MIN) return S32_MIN[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    function automatic int find_dead(input int from);
        for (int i = from; i < POOL_DEPTH; i++)
            if (pool_life[i] <= 0) return i;
        return -1;
    endfunction

    task automatic apply_pool_op(input logic [1:0] op, input logic [DT_W-1:0] dt,
                                 input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                                 input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py);
        t_res   r;
        longint dtl;
        int     live;
        int     hit;
        int     n;
        dtl = dt;
        r = '0;
        r.last = 1'b1;
        case (op)
            OP_TICK: begin
                live = 0;
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    if (pool_life[i] > 0) begin
                        pool_vx[i] = sat32(longint'(pool_vx[i])
                                           + ((longint'(cfg_gx) * dtl) >>> FRAC_W));
                        pool_vy[i] = sat32(longint'(pool_vy[i])
                                           + ((longint'(cfg_gy) * dtl) >>> FRAC_W));
                        pool_px[i] = sat32(longint'(pool_px[i])
                                           + ((longint'(pool_vx[i]) * dtl) >>> FRAC_W));
                        pool_py[i] = sat32(longint'(pool_py[i])
                                           + ((longint'(pool_vy[i]) * dtl) >>> FRAC_W));
                        pool_life[i] = DATA_W'(longint'(pool_life[i]) - dtl);
                    end
                    if (pool_life[i] > 0) live++;
                end
                tick_live = live;
                r.kind = KIND_TICK;
                r.live_total = LIVE_W'(live);
                due_results.push_back(r);
            end
            OP_ADD: begin
                hit = -1;
                if (fill_ptr_ok) hit = find_dead(fill_ptr);
                if (hit < 0) hit = find_dead(0);
                r.kind = KIND_ADD;
                if (hit >= 0) begin
                    pool_vx[hit] = vx;
                    pool_vy[hit] = vy;
                    pool_px[hit] = px;
                    pool_py[hit] = py;
                    pool_life[hit] = {1'b0, cfg_life};
                    fill_ptr = hit;
                    fill_ptr_ok = 1'b1;
                    r.slot = SLOT_W'(hit);
                    r.valid_res = 1'b1;
                end
                due_results.push_back(r);
            end
            OP_DUMP: begin
                n = 0;
                for (int i = 0; i < POOL_DEPTH && n < tick_live; i++) begin
                    if (pool_life[i] > 0) begin
                        r = '0;
                        r.kind = KIND_REC;
                        r.slot = SLOT_W'(i);
                        r.valid_res = 1'b1;
                        r.pos_x = pool_px[i];
                        r.pos_y = pool_py[i];
                        r.life = pool_life[i];
                        due_results.push_back(r);
                        n++;
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.kind = KIND_REC;
                    r.last = 1'b1;
                    due_results.push_back(r);
                end else begin
                    r = due_results.pop_back();
                    r.last = 1'b1;
                    due_results.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endtask

    // result side: random stalls, plus long hold-offs on demand
    always @(posedge i_clk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("result with nothing expected: kind %0d slot %0d", o_kind, o_slot);
                err_cnt++;
            end else begin
                seen_want = due_results.pop_front();
                check_field("kind", seen_want.kind, o_kind);
                check_field("live_total", seen_want.live_total, o_live_total);
                check_field("slot", seen_want.slot, o_slot);
                check_field("valid_res", seen_want.valid_res, o_valid_res);
                check_field("out_pos_x", seen_want.pos_x, o_out_pos_x);
                check_field("out_pos_y", seen_want.pos_y, o_out_pos_y);
                check_field("out_life", seen_want.life, o_out_life);
                check_field("last", seen_want.last, o_last);
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [DT_W-1:0] dt,
                            input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                            input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_delta_time <= dt;
        i_vel_x <= vx;
        i_vel_y <= vy;
        i_pos_x <= px;
        i_pos_y <= py;
        do @(posedge i_clk); while (!o_in_ready);
        apply_pool_op(op, dt, vx, vy, px, py);
    endtask

    task automatic tick_req(input logic [DT_W-1:0] dt);
        send_req(OP_TICK, dt, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic add_req(input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                           input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py);
        send_req(OP_ADD, DT_W'($urandom), vx, vy, px, py);
    endtask

    task automatic dump_req();
        send_req(OP_DUMP, DT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic noise_req();
        send_req(OP_NONE, DT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // sender holds until every result is in, then lets the block go quiet
    task automatic settle_pool();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [DATA_W-1:0] gx, input logic [DATA_W-1:0] gy,
                                input logic [LIFE_W-1:0] life);
        settle_pool();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_GRAV_X;
        i_cfg_data <= gx;
        @(posedge i_clk);
        i_cfg_idx <= CFG_GRAV_Y;
        i_cfg_data <= gy;
        @(posedge i_clk);
        i_cfg_idx <= CFG_LIFETIME;
        i_cfg_data <= {1'b0, life};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_gx = gx;
        cfg_gy = gy;
        cfg_life = life;
    endtask

    function automatic logic [DATA_W-1:0] rand_q16();
        if ($urandom_range(1)) return $urandom;
        return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        int unsigned roll;
        int unsigned cap;
        roll = $urandom_range(99);
        cap = cfg_life >> 2;
        if (cap > 32'hF_FFFF) cap = 32'hF_FFFF;
        if (roll < 10) return '0;
        if (roll < 30) return DT_W'($urandom);
        return DT_W'($urandom_range(0, cap));
    endfunction

    task automatic random_req();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) add_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        else if (roll < 75) tick_req(rand_dt());
        else if (roll < 95) dump_req();
        else noise_req();
    endtask

    task automatic test_empty_pool();
        set_idling(0, 0);
        tick_req('0);
        dump_req();
        noise_req();
        tick_req('1);
        dump_req();
    endtask

    // full-scale gravity, velocity and position with the longest step
    task automatic test_extreme_values();
        program_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req('0, '0, '0, '0);
        tick_req('1);
        dump_req();
        tick_req('0);
        dump_req();
    endtask

    task automatic test_short_lifetimes();
        // zero lifetime: stored dead, next add reuses the slot
        program_regs(32'hFFFF_FFFF, 32'h0000_0001, '0);
        add_req(32'h0001_0000, 32'hFFFF_0000, 32'h0000_1000, 32'hFFFF_F000);
        add_req(32'h0002_0000, 32'hFFFE_0000, 32'h0000_2000, 32'hFFFF_E000);
        dump_req();
        // one unit of life, gone after a one-unit step; gravity floor of -1
        program_regs(32'hFFFF_FFFF, 32'h0000_0001, 31'd1);
        add_req(32'hFFFF_FFFF, 32'h0000_0001, '0, '0);
        tick_req(20'd1);
        dump_req();
        // dump limited to the live count of the last tick
        program_regs('0, '0, LIFE_RST);
        tick_req('0);
        add_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        dump_req();
    endtask

    task automatic test_pool_full();
        set_idling(11, 11);
        program_regs(rand_q16(), rand_q16(), 31'h0008_0000);
        repeat (30) add_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        program_regs(rand_q16(), rand_q16(), 31'h0020_0000);
        repeat (36) add_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        tick_req(20'd1);
        dump_req();
    endtask

    task automatic test_output_backpressure();
        settle_pool();
        set_idling(0, 0);
        stall_req = 600;
        repeat (3) dump_req();
        tick_req(20'd1);
        dump_req();
        settle_pool();
        // expire the short-lived batch, then wrap the next-fit search
        tick_req('1);
        dump_req();
        repeat (3) add_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
        tick_req('0);
        dump_req();
    endtask

    task automatic test_random_mix();
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 87, 0, 11};
        recv_pct = '{0, 0, 87, 11};
        for (int p = 0; p < 4; p++) begin
            program_regs(rand_q16(), rand_q16(),
                         LIFE_W'($urandom_range(32'h1_0000, 32'h20_0000)));
            set_idling(send_pct[p], recv_pct[p]);
            repeat (5) random_req();
        end
    endtask

    initial begin
        foreach (pool_life[i]) begin
            pool_vx[i] = '0;
            pool_vy[i] = '0;
            pool_px[i] = '0;
            pool_py[i] = '0;
            pool_life[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_pool();
        test_extreme_values();
        test_short_lifetimes();
        test_pool_full();
        test_output_backpressure();
        test_random_mix();
        settle_pool();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pim_pkg.sv
rtl/core/pim_store.sv
rtl/core/pim_euler.sv
rtl/core/particle_pool_integrator.sv
dv/particle_pool_integrator_tb.sv
